// ===== hdl/bos_pkg.sv =====
// ============================================================================
// bos_pkg
// Shared types and constants of the box overlap suppressor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bos_pkg;

    // Overlap ratio limit: unsigned Q0.16
    localparam int THR_W = 16;
    localparam int Q_SHIFT = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd22938;

    // Outcome of one pair test
    typedef struct packed {
        logic done;
        logic hit;
        logic keep_i;
    } pair_res_t;

endpackage

`default_nettype wire

// ===== hdl/bos_ram.sv =====
// ============================================================================
// bos_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/bos_mul.sv =====
// ============================================================================
// bos_mul
// Shared unsigned multiplier with a registered product.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bos_mul #(
    parameter int A_W = 26,
    parameter int B_W = 16
) (
    input  wire logic               clk,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic      [A_W+B_W-1:0] p
);

    always_ff @(posedge clk)
    begin
        p <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
    end

endmodule

`default_nettype wire

// ===== hdl/bos_pair.sv =====
// ============================================================================
// bos_pair
// Overlap test of one box pair: intersection, union and exact Q0.16 ratio
// compare, with both products taken from one shared multiplier.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bos_pair #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [bos_pkg::THR_W-1:0]   thr,
    input  wire logic [COORD_BITS-1:0]       i_left,
    input  wire logic [COORD_BITS-1:0]       i_top,
    input  wire logic [COORD_BITS:0]         i_width,
    input  wire logic [COORD_BITS:0]         i_height,
    input  wire logic [2*COORD_BITS:0]       i_area,
    input  wire logic [COORD_BITS-1:0]       j_left,
    input  wire logic [COORD_BITS-1:0]       j_top,
    input  wire logic [COORD_BITS:0]         j_width,
    input  wire logic [COORD_BITS:0]         j_height,
    input  wire logic [2*COORD_BITS:0]       j_area,
    output bos_pkg::pair_res_t               res
);

    import bos_pkg::*;

    localparam int POS_W   = COORD_BITS;
    localparam int SIZE_W  = COORD_BITS + 1;
    localparam int AREA_W  = 2 * COORD_BITS + 1;
    localparam int INTER_W = 2 * SIZE_W;
    localparam int UNI_W   = INTER_W + 2;
    localparam int MUL_A   = INTER_W;
    localparam int MUL_B   = (SIZE_W > THR_W) ? SIZE_W : THR_W;
    localparam int P_W     = MUL_A + MUL_B;
    localparam int CMP_W   = P_W + Q_SHIFT;

    typedef enum logic [2:0] {
        P_IDLE,
        P_INTER,
        P_UNION,
        P_THR,
        P_CMP
    } pstate_t;

    pstate_t             state_reg, state_next;
    logic [SIZE_W-1:0]   iw_reg, iw_next;
    logic [SIZE_W-1:0]   ih_reg, ih_next;
    logic [AREA_W-1:0]   ai_reg, ai_next;
    logic [AREA_W-1:0]   aj_reg, aj_next;
    logic [INTER_W-1:0]  inter_reg, inter_next;
    logic [UNI_W-1:0]    uni_reg, uni_next;
    logic                uni_pos_reg, uni_pos_next;

    logic [MUL_A-1:0]    mul_a;
    logic [MUL_B-1:0]    mul_b;
    logic [P_W-1:0]      prod;
    logic [CMP_W-1:0]    lhs;
    logic [CMP_W-1:0]    rhs;

    function automatic logic [SIZE_W-1:0] span(
        input logic [POS_W-1:0]  a0,
        input logic [SIZE_W-1:0] alen,
        input logic [POS_W-1:0]  b0,
        input logic [SIZE_W-1:0] blen
    );
        logic [POS_W+1:0] hi_a;
        logic [POS_W+1:0] hi_b;
        logic [POS_W+1:0] hi;
        logic [POS_W+1:0] lo;
        logic [POS_W+1:0] diff;
        hi_a = (POS_W + 2)'(a0) + (POS_W + 2)'(alen);
        hi_b = (POS_W + 2)'(b0) + (POS_W + 2)'(blen);
        hi   = (hi_a < hi_b) ? hi_a : hi_b;
        lo   = (a0 > b0) ? (POS_W + 2)'(a0) : (POS_W + 2)'(b0);
        diff = hi - lo;
        return (hi > lo) ? diff[SIZE_W-1:0] : '0;
    endfunction

    bos_mul #(
        .A_W (MUL_A),
        .B_W (MUL_B)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Operand select for the shared multiplier
    always_comb
    begin
        if (state_reg == P_THR)
        begin
            mul_a = uni_reg[MUL_A-1:0];
            mul_b = MUL_B'(thr);
        end
        else
        begin
            mul_a = MUL_A'(iw_reg);
            mul_b = MUL_B'(ih_reg);
        end
    end

    assign lhs = CMP_W'({inter_reg, {Q_SHIFT{1'b0}}});
    assign rhs = CMP_W'(prod);

    always_comb
    begin
        state_next   = state_reg;
        iw_next      = iw_reg;
        ih_next      = ih_reg;
        ai_next      = ai_reg;
        aj_next      = aj_reg;
        inter_next   = inter_reg;
        uni_next     = uni_reg;
        uni_pos_next = uni_pos_reg;
        res          = '0;

        case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    iw_next    = span(i_left, i_width, j_left, j_width);
                    ih_next    = span(i_top, i_height, j_top, j_height);
                    ai_next    = i_area;
                    aj_next    = j_area;
                    state_next = P_INTER;
                end
            end
            P_INTER:
            begin
                state_next = P_UNION;
            end
            P_UNION:
            begin
                inter_next   = prod[INTER_W-1:0];
                uni_next     = UNI_W'(ai_reg) + UNI_W'(aj_reg) - UNI_W'(prod[INTER_W-1:0]);
                uni_pos_next = !uni_next[UNI_W-1] && (|uni_next);
                state_next   = P_THR;
            end
            P_THR:
            begin
                state_next = P_CMP;
            end
            P_CMP:
            begin
                res.done   = 1'b1;
                res.hit    = uni_pos_reg && (lhs > rhs);
                res.keep_i = ai_reg > aj_reg;
                state_next = P_IDLE;
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iw_reg      <= iw_next;
        ih_reg      <= ih_next;
        ai_reg      <= ai_next;
        aj_reg      <= aj_next;
        inter_reg   <= inter_next;
        uni_reg     <= uni_next;
        uni_pos_reg <= uni_pos_next;
    end

endmodule

`default_nettype wire

// ===== hdl/box_overlap_suppressor_unit.sv =====
// ============================================================================
// box_overlap_suppressor_unit
// Greedy IoU non-maximum suppression over a list of up to MAX_BOXES boxes.
// ============================================================================
//
//   Channel  Handshake              Payload
//   box      box_valid/box_stall    box_left..box_area, list_end, list_empty
//   kept     kept_valid/kept_stall  kept_left..kept_area, kept_last,
//                                   none_kept, overflowed
//   cfg      cfg_valid/cfg_ready    cfg_data = iou_threshold (Q0.16)
//
// Loading takes one cycle per box. On list_end the block stalls its input
// while suppression runs: each live pair goes through a slot scan, a RAM
// read and the pair unit with its shared multiplier, each removed or
// skipped slot takes one scan step, and each i pass adds a seek and a RAM
// read of box i. Survivors then leave one at a time, each after a slot
// seek and a RAM read. Reset clears the list and sets the threshold to 0.35; no clearing pass.
//
`timescale 1ns / 1ps
`default_nettype none

module box_overlap_suppressor_unit #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [bos_pkg::THR_W-1:0] cfg_data,

    input  wire logic                      box_valid,
    output logic                           box_stall,
    input  wire logic [COORD_BITS-1:0]     box_left,
    input  wire logic [COORD_BITS-1:0]     box_top,
    input  wire logic [COORD_BITS:0]       box_width,
    input  wire logic [COORD_BITS:0]       box_height,
    input  wire logic [2*COORD_BITS:0]     box_area,
    input  wire logic                      list_end,
    input  wire logic                      list_empty,

    output logic                           kept_valid,
    input  wire logic                      kept_stall,
    output logic      [COORD_BITS-1:0]     kept_left,
    output logic      [COORD_BITS-1:0]     kept_top,
    output logic      [COORD_BITS:0]       kept_width,
    output logic      [COORD_BITS:0]       kept_height,
    output logic      [2*COORD_BITS:0]     kept_area,
    output logic                           kept_last,
    output logic                           none_kept,
    output logic                           overflowed
);

    import bos_pkg::*;

    localparam int POS_W    = COORD_BITS;
    localparam int SIZE_W   = COORD_BITS + 1;
    localparam int AREA_W   = 2 * COORD_BITS + 1;
    localparam int CORNER_W = 2 * POS_W;
    localparam int EXTENT_W = 2 * SIZE_W + AREA_W;
    localparam int IDX_W    = $clog2(MAX_BOXES);
    localparam int CNT_W    = $clog2(MAX_BOXES + 1);

    typedef enum logic [3:0] {
        S_LOAD,
        S_EMPTY,
        S_I_RD,
        S_I_CAP,
        S_J_SCAN,
        S_J_CAP,
        S_J_WAIT,
        S_I_SEEK,
        S_O_SEEK,
        S_O_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [THR_W-1:0]      thr_reg, thr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [MAX_BOXES-1:0]  alive_reg, alive_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    logic [CNT_W-1:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]      live_reg, live_next;
    logic                  skip_reg, skip_next;

    logic [POS_W-1:0]      il_reg, il_next;
    logic [POS_W-1:0]      it_reg, it_next;
    logic [SIZE_W-1:0]     iw_reg, iw_next;
    logic [SIZE_W-1:0]     ih_reg, ih_next;
    logic [AREA_W-1:0]     ia_reg, ia_next;

    logic                  kv_reg, kv_next;
    logic [POS_W-1:0]      kl_reg, kl_next;
    logic [POS_W-1:0]      kt_reg, kt_next;
    logic [SIZE_W-1:0]     kw_reg, kw_next;
    logic [SIZE_W-1:0]     kh_reg, kh_next;
    logic [AREA_W-1:0]     ka_reg, ka_next;
    logic                  klast_reg, klast_next;
    logic                  knone_reg, knone_next;
    logic                  kovf_reg, kovf_next;

    logic                  we;
    logic [IDX_W-1:0]      raddr;
    logic [IDX_W-1:0]      cur_idx;
    logic [CORNER_W-1:0]   corner_wdata, corner_rdata;
    logic [EXTENT_W-1:0]   extent_wdata, extent_rdata;
    logic [POS_W-1:0]      rd_left, rd_top;
    logic [SIZE_W-1:0]     rd_width, rd_height;
    logic [AREA_W-1:0]     rd_area;
    logic                  pair_start;
    pair_res_t             pair_res;
    logic                  out_free;
    logic                  store;
    logic [CNT_W-1:0]      i_plus1;

    assign cfg_ready = 1'b1;
    assign box_stall = (state_reg != S_LOAD);

    assign kept_valid  = kv_reg;
    assign kept_left   = kl_reg;
    assign kept_top    = kt_reg;
    assign kept_width  = kw_reg;
    assign kept_height = kh_reg;
    assign kept_area   = ka_reg;
    assign kept_last   = klast_reg;
    assign none_kept   = knone_reg;
    assign overflowed  = kovf_reg;

    assign out_free = !kv_reg || !kept_stall;
    assign cur_idx  = cur_reg[IDX_W-1:0];
    assign raddr    = (state_reg == S_I_RD) ? i_reg : cur_idx;
    assign i_plus1  = CNT_W'(i_reg) + CNT_W'(1);

    assign store        = !(list_end && list_empty);
    assign corner_wdata = {box_left, box_top};
    assign extent_wdata = {box_width, box_height, box_area};

    assign rd_left   = corner_rdata[CORNER_W-1 -: POS_W];
    assign rd_top    = corner_rdata[POS_W-1:0];
    assign rd_width  = extent_rdata[EXTENT_W-1 -: SIZE_W];
    assign rd_height = extent_rdata[AREA_W +: SIZE_W];
    assign rd_area   = extent_rdata[AREA_W-1:0];

    bos_ram #(
        .WIDTH (CORNER_W),
        .DEPTH (MAX_BOXES)
    ) u_corner_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (corner_wdata),
        .raddr (raddr),
        .rdata (corner_rdata)
    );

    bos_ram #(
        .WIDTH (EXTENT_W),
        .DEPTH (MAX_BOXES)
    ) u_extent_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (extent_wdata),
        .raddr (raddr),
        .rdata (extent_rdata)
    );

    bos_pair #(
        .COORD_BITS (COORD_BITS)
    ) u_pair (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pair_start),
        .thr      (thr_reg),
        .i_left   (il_reg),
        .i_top    (it_reg),
        .i_width  (iw_reg),
        .i_height (ih_reg),
        .i_area   (ia_reg),
        .j_left   (rd_left),
        .j_top    (rd_top),
        .j_width  (rd_width),
        .j_height (rd_height),
        .j_area   (rd_area),
        .res      (pair_res)
    );

    always_comb
    begin
        state_next = state_reg;
        thr_next   = thr_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        alive_next = alive_reg;
        i_next     = i_reg;
        cur_next   = cur_reg;
        live_next  = live_reg;
        skip_next  = skip_reg;
        il_next    = il_reg;
        it_next    = it_reg;
        iw_next    = iw_reg;
        ih_next    = ih_reg;
        ia_next    = ia_reg;
        kv_next    = kv_reg && kept_stall;
        kl_next    = kl_reg;
        kt_next    = kt_reg;
        kw_next    = kw_reg;
        kh_next    = kh_reg;
        ka_next    = ka_reg;
        klast_next = klast_reg;
        knone_next = knone_reg;
        kovf_next  = kovf_reg;
        we         = 1'b0;
        pair_start = 1'b0;

        if (cfg_valid)
        begin
            thr_next = cfg_data;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (box_valid)
                begin
                    if (store)
                    begin
                        if (count_reg < CNT_W'(MAX_BOXES))
                        begin
                            we                              = 1'b1;
                            alive_next[count_reg[IDX_W-1:0]] = 1'b1;
                            count_next                      = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (list_end)
                    begin
                        if (count_next == '0)
                        begin
                            state_next = S_EMPTY;
                        end
                        else
                        begin
                            i_next     = '0;
                            live_next  = count_next;
                            state_next = S_I_RD;
                        end
                    end
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    kv_next    = 1'b1;
                    kl_next    = '0;
                    kt_next    = '0;
                    kw_next    = '0;
                    kh_next    = '0;
                    ka_next    = '0;
                    klast_next = 1'b1;
                    knone_next = 1'b1;
                    kovf_next  = ovf_reg;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            S_I_RD:
            begin
                state_next = S_I_CAP;
            end
            S_I_CAP:
            begin
                il_next    = rd_left;
                it_next    = rd_top;
                iw_next    = rd_width;
                ih_next    = rd_height;
                ia_next    = rd_area;
                cur_next   = i_plus1;
                state_next = S_J_SCAN;
            end
            S_J_SCAN:
            begin
                if (cur_reg >= count_reg)
                begin
                    cur_next   = i_plus1;
                    skip_next  = 1'b0;
                    state_next = S_I_SEEK;
                end
                else if (!alive_reg[cur_idx])
                begin
                    cur_next = cur_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_J_CAP;
                end
            end
            S_J_CAP:
            begin
                pair_start = 1'b1;
                state_next = S_J_WAIT;
            end
            S_J_WAIT:
            begin
                if (pair_res.done)
                begin
                    if (pair_res.hit && pair_res.keep_i)
                    begin
                        // drop j, keep scanning
                        alive_next[cur_idx] = 1'b0;
                        live_next           = live_reg - CNT_W'(1);
                        cur_next            = cur_reg + CNT_W'(1);
                        state_next          = S_J_SCAN;
                    end
                    else if (pair_res.hit)
                    begin
                        // drop i; the box that takes its slot is passed over
                        alive_next[i_reg] = 1'b0;
                        live_next         = live_reg - CNT_W'(1);
                        cur_next          = i_plus1;
                        skip_next         = 1'b1;
                        state_next        = S_I_SEEK;
                    end
                    else
                    begin
                        cur_next   = cur_reg + CNT_W'(1);
                        state_next = S_J_SCAN;
                    end
                end
            end
            S_I_SEEK:
            begin
                if (cur_reg >= count_reg)
                begin
                    cur_next   = '0;
                    state_next = S_O_SEEK;
                end
                else if (!alive_reg[cur_idx])
                begin
                    cur_next = cur_reg + CNT_W'(1);
                end
                else if (skip_reg)
                begin
                    skip_next = 1'b0;
                    cur_next  = cur_reg + CNT_W'(1);
                end
                else
                begin
                    i_next     = cur_idx;
                    state_next = S_I_RD;
                end
            end
            S_O_SEEK:
            begin
                if (!alive_reg[cur_idx])
                begin
                    cur_next = cur_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_O_EMIT;
                end
            end
            S_O_EMIT:
            begin
                if (out_free)
                begin
                    kv_next    = 1'b1;
                    kl_next    = rd_left;
                    kt_next    = rd_top;
                    kw_next    = rd_width;
                    kh_next    = rd_height;
                    ka_next    = rd_area;
                    klast_next = (live_reg == CNT_W'(1));
                    knone_next = 1'b0;
                    kovf_next  = ovf_reg;
                    live_next  = live_reg - CNT_W'(1);
                    cur_next   = cur_reg + CNT_W'(1);
                    if (live_reg == CNT_W'(1))
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_O_SEEK;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            thr_reg   <= THR_RESET;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            alive_reg <= '0;
            i_reg     <= '0;
            cur_reg   <= '0;
            live_reg  <= '0;
            skip_reg  <= 1'b0;
            kv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            alive_reg <= alive_next;
            i_reg     <= i_next;
            cur_reg   <= cur_next;
            live_reg  <= live_next;
            skip_reg  <= skip_next;
            kv_reg    <= kv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        il_reg    <= il_next;
        it_reg    <= it_next;
        iw_reg    <= iw_next;
        ih_reg    <= ih_next;
        ia_reg    <= ia_next;
        kl_reg    <= kl_next;
        kt_reg    <= kt_next;
        kw_reg    <= kw_next;
        kh_reg    <= kh_next;
        ka_reg    <= ka_next;
        klast_reg <= klast_next;
        knone_reg <= knone_next;
        kovf_reg  <= kovf_next;
    end

endmodule

`default_nettype wire

// ===== test/tb_box_overlap_suppressor_unit.sv =====
// ============================================================================
// tb_box_overlap_suppressor_unit
// Self-checking bench for the greedy IoU box suppressor. Box lists are fed
// over the stall handshake under several overlap thresholds. Each list is
// run through a local model of the pairwise suppression, and every kept box
// is compared in order against the boxes that model says must survive.
// ============================================================================
`timescale 1ns / 1ps

module tb_box_overlap_suppressor_unit;

    import bos_pkg::*;

    localparam int CB = 12;
    localparam int SW = CB + 1;
    localparam int AW = 2 * CB + 1;
    localparam int MAX_BOXES = 64;
    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 4;

    typedef struct packed {
        logic [CB-1:0] left;
        logic [CB-1:0] top;
        logic [SW-1:0] width;
        logic [SW-1:0] height;
        logic [AW-1:0] area;
        logic          list_end;
        logic          list_empty;
    } box_req_t;

    typedef struct packed {
        logic [CB-1:0] left;
        logic [CB-1:0] top;
        logic [SW-1:0] width;
        logic [SW-1:0] height;
        logic [AW-1:0] area;
        logic          is_last;
        logic          is_none;
        logic          ovf;
    } kept_res_t;

    // Holds the current list, runs the suppression on list end and keeps
    // the surviving boxes in emission order.
    class kept_scoreboard;
        box_req_t          held[$];
        kept_res_t         survivors[$];
        bit                overflow_seen;
        logic [THR_W-1:0]  threshold;
        int                errors;
        int                reported;
        int                checked;
        int                lists;
        int                overflow_lists;
        int                removals;

        function new();
            threshold = THR_RESET;
        endfunction

        function void set_threshold(logic [THR_W-1:0] value);
            threshold = value;
        endfunction

        function int pending();
            return survivors.size();
        endfunction

        function longint span_overlap(longint a0, longint alen, longint b0, longint blen);
            longint hi;
            longint lo;
            hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
            lo = (a0 > b0) ? a0 : b0;
            return (hi > lo) ? hi - lo : 0;
        endfunction

        function bit too_close(box_req_t p, box_req_t q);
            longint ov_w;
            longint ov_h;
            longint inter;
            longint uni;
            ov_w = span_overlap(longint'(p.left), longint'(p.width),
                                longint'(q.left), longint'(q.width));
            ov_h = span_overlap(longint'(p.top), longint'(p.height),
                                longint'(q.top), longint'(q.height));
            inter = ov_w * ov_h;
            uni = longint'(p.area) + longint'(q.area) - inter;
            if (uni <= 0)
                return 1'b0;
            return inter * 65536 > longint'(threshold) * uni;
        endfunction

        // Losing j keeps j in place for a retest; losing i ends the i pass,
        // so the box shifted into slot i is never used as i.
        function void suppress_held();
            int i;
            int j;
            i = 0;
            while (i < held.size())
            begin
                j = i + 1;
                while (j < held.size())
                begin
                    if (too_close(held[i], held[j]))
                    begin
                        removals++;
                        if (held[i].area > held[j].area)
                            held.delete(j);
                        else
                        begin
                            held.delete(i);
                            break;
                        end
                    end
                    else
                        j++;
                end
                i++;
            end
        endfunction

        function void note_box(box_req_t b);
            kept_res_t r;
            if (!(b.list_end && b.list_empty))
            begin
                if (held.size() < MAX_BOXES)
                    held = {held, b};
                else
                    overflow_seen = 1'b1;
            end
            if (!b.list_end)
                return;
            lists++;
            if (overflow_seen)
                overflow_lists++;
            if (held.size() == 0)
            begin
                r = '0;
                r.is_last = 1'b1;
                r.is_none = 1'b1;
                r.ovf = overflow_seen;
                survivors = {survivors, r};
            end
            else
            begin
                suppress_held();
                foreach (held[k])
                begin
                    r.left = held[k].left;
                    r.top = held[k].top;
                    r.width = held[k].width;
                    r.height = held[k].height;
                    r.area = held[k].area;
                    r.is_last = (k == held.size() - 1);
                    r.is_none = 1'b0;
                    r.ovf = overflow_seen;
                    survivors = {survivors, r};
                end
            end
            held.delete();
            overflow_seen = 1'b0;
        endfunction

        function void check_kept(kept_res_t got);
            kept_res_t want;
            checked++;
            if (survivors.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("kept box with nothing pending: L%0d T%0d W%0d H%0d A%0d",
                             got.left, got.top, got.width, got.height, got.area);
                end
                return;
            end
            want = survivors.pop_front();
            if (got.left !== want.left || got.top !== want.top
                || got.width !== want.width || got.height !== want.height
                || got.area !== want.area || got.is_last !== want.is_last
                || got.is_none !== want.is_none || got.ovf !== want.ovf)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("kept box %0d mismatch", checked);
                    $display("  expected L%0d T%0d W%0d H%0d A%0d last%0b none%0b ovf%0b",
                             want.left, want.top, want.width, want.height, want.area,
                             want.is_last, want.is_none, want.ovf);
                    $display("  actual   L%0d T%0d W%0d H%0d A%0d last%0b none%0b ovf%0b",
                             got.left, got.top, got.width, got.height, got.area,
                             got.is_last, got.is_none, got.ovf);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [THR_W-1:0]   cfg_data;
    logic               box_valid;
    logic               box_stall;
    logic [CB-1:0]      box_left;
    logic [CB-1:0]      box_top;
    logic [SW-1:0]      box_width;
    logic [SW-1:0]      box_height;
    logic [AW-1:0]      box_area;
    logic               list_end;
    logic               list_empty;
    logic               kept_valid;
    logic               kept_stall;
    logic [CB-1:0]      kept_left;
    logic [CB-1:0]      kept_top;
    logic [SW-1:0]      kept_width;
    logic [SW-1:0]      kept_height;
    logic [AW-1:0]      kept_area;
    logic               kept_last;
    logic               none_kept;
    logic               overflowed;

    kept_scoreboard     sb;
    kept_res_t          seen_kept;
    int                 sent_count;
    int                 cycle_count;
    bit                 hold_go;
    bit                 hold_done;

    box_overlap_suppressor_unit #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (CB)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .box_valid   (box_valid),
        .box_stall   (box_stall),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height),
        .box_area    (box_area),
        .list_end    (list_end),
        .list_empty  (list_empty),
        .kept_valid  (kept_valid),
        .kept_stall  (kept_stall),
        .kept_left   (kept_left),
        .kept_top    (kept_top),
        .kept_width  (kept_width),
        .kept_height (kept_height),
        .kept_area   (kept_area),
        .kept_last   (kept_last),
        .none_kept   (none_kept),
        .overflowed  (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d kept boxes outstanding",
                 cycle_count, sb.pending());
        $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, a quiet stretch, and one long hold-off.
    initial
    begin
        bit quiet;
        kept_stall = 1'b0;
        hold_done = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                kept_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                quiet = (sb.checked >= 30 && sb.checked < 70);
                kept_stall <= !quiet && ($urandom_range(99) < 20);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && kept_valid && !kept_stall)
        begin
            seen_kept.left = kept_left;
            seen_kept.top = kept_top;
            seen_kept.width = kept_width;
            seen_kept.height = kept_height;
            seen_kept.area = kept_area;
            seen_kept.is_last = kept_last;
            seen_kept.is_none = none_kept;
            seen_kept.ovf = overflowed;
            sb.check_kept(seen_kept);
        end
    end

    // Offer one request and hold it until accepted.
    task automatic offer_box(input box_req_t b);
        if (!(sent_count >= 40 && sent_count < 80) && $urandom_range(99) < 20)
        begin
            box_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        box_valid <= 1'b1;
        box_left <= b.left;
        box_top <= b.top;
        box_width <= b.width;
        box_height <= b.height;
        box_area <= b.area;
        list_end <= b.list_end;
        list_empty <= b.list_empty;
        do @(posedge clk); while (box_stall);
        sb.note_box(b);
        sent_count++;
    endtask

    task automatic put(input int left, input int top, input int w, input int h,
                       input int a, input bit e, input bit em);
        box_req_t b;
        b.left = CB'(left);
        b.top = CB'(top);
        b.width = SW'(w);
        b.height = SW'(h);
        b.area = AW'(a);
        b.list_end = e;
        b.list_empty = em;
        offer_box(b);
    endtask

    // Mostly boxes of similar size near one corner, some pure noise.
    function automatic box_req_t cluster_box(int cx, int cy);
        box_req_t b;
        int w;
        int h;
        if ($urandom_range(99) < 10)
        begin
            b.left = CB'($urandom);
            b.top = CB'($urandom);
            b.width = SW'($urandom);
            b.height = SW'($urandom);
            b.area = AW'($urandom);
        end
        else
        begin
            w = $urandom_range(120, 20);
            h = $urandom_range(120, 20);
            b.left = CB'(cx + $urandom_range(30));
            b.top = CB'(cy + $urandom_range(30));
            b.width = SW'(w);
            b.height = SW'(h);
            b.area = AW'($urandom_range(w * h, (w * h * 3) / 4));
        end
        b.list_end = 1'b0;
        b.list_empty = 1'b0;
        return b;
    endfunction

    task automatic send_random_list();
        int n;
        int cx;
        int cy;
        bit close_with_box;
        box_req_t b;
        n = $urandom_range(6);
        cx = $urandom_range(4095);
        cy = $urandom_range(4095);
        close_with_box = (n > 0) && ($urandom_range(1) == 1);
        for (int k = 0; k < n; k++)
        begin
            b = cluster_box(cx, cy);
            b.list_end = close_with_box && (k == n - 1);
            b.list_empty = !b.list_end && ($urandom_range(9) == 0);
            offer_box(b);
        end
        if (!close_with_box)
        begin
            // end marker: its box fields are don't-care
            b = cluster_box(cx, cy);
            b.list_end = 1'b1;
            b.list_empty = 1'b1;
            offer_box(b);
        end
    endtask

    // Fill past capacity so the tail boxes and the closing box are dropped.
    task automatic send_full_list();
        int cx;
        int cy;
        box_req_t b;
        for (int k = 0; k <= MAX_BOXES + 2; k++)
        begin
            if (k % 6 == 0)
            begin
                cx = $urandom_range(4095);
                cy = $urandom_range(4095);
            end
            b = cluster_box(cx, cy);
            b.list_end = (k == MAX_BOXES + 2);
            offer_box(b);
        end
    endtask

    task automatic drain_results();
        box_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_threshold(value);
    endtask

    initial
    begin
        logic [THR_W-1:0] thr;
        int phase_start;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        box_valid = 1'b0;
        box_left = '0;
        box_top = '0;
        box_width = '0;
        box_height = '0;
        box_area = '0;
        list_end = 1'b0;
        list_empty = 1'b0;
        hold_go = 1'b0;
        sent_count = 0;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list
        put(0, 0, 0, 0, 0, 1, 1);
        // list_empty on a box that does not end the list is ignored
        put(100, 100, 50, 50, 2500, 0, 1);
        put(400, 400, 50, 50, 2500, 1, 0);
        // field extremes, including out-of-range sizes and areas
        put(4095, 4095, 4096, 4096, 16777216, 0, 0);
        put(0, 0, 0, 0, 0, 0, 0);
        put(4095, 0, 8191, 8191, 33554431, 0, 0);
        put(0, 4095, 8191, 8191, 33554431, 0, 0);
        put(1234, 567, 89, 10, 999, 1, 1);
        // equal areas: box i goes
        put(200, 200, 40, 40, 1600, 0, 0);
        put(200, 200, 40, 40, 1600, 1, 0);
        // larger i removes two later boxes in turn
        put(10, 10, 60, 60, 3600, 0, 0);
        put(12, 12, 60, 60, 3000, 0, 0);
        put(14, 8, 60, 60, 3100, 1, 0);
        // negative union: never suppressed
        put(500, 500, 100, 100, 10, 0, 0);
        put(500, 500, 100, 100, 10, 1, 0);
        // box shifted into slot i after i is removed is never used as i
        put(0, 2000, 100, 100, 10000, 0, 0);
        put(0, 2000, 100, 100, 10001, 0, 0);
        put(10, 2000, 100, 100, 10000, 1, 0);
        drain_results();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: thr = '0;
                1: thr = '1;
                2: thr = THR_W'($urandom);
                3: thr = 16'h8000;
                default: thr = THR_RESET;
            endcase
            write_threshold(thr);
            if (p == 1)
                hold_go = 1'b1;
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_ITEMS)
                send_random_list();
            if (p == 2)
                send_full_list();
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d box requests in %0d lists (%0d past capacity), five thresholds",
                 sent_count, sb.lists, sb.overflow_lists);
        $display("%0d kept boxes checked, %0d overlap removals predicted, %0d errors",
                 sb.checked, sb.removals, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
